// ===== hw/rtl/rslb_pkg.sv =====
// shared types and constants of the radar spoke run-length blob extractor
package rslb_pkg;

  localparam int unsigned ANGLE_W    = 11;
  localparam int unsigned RADIUS_W   = 11;
  localparam int unsigned STRENGTH_W = 8;
  localparam int unsigned CLASS_W    = 3;
  localparam int unsigned MAP_DEPTH  = 256;

  // both queues hold four entries
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_MAP_WRITE = 1'b1;

  localparam logic [CLASS_W-1:0] CLASS_NONE = '0;

  typedef struct packed {
    logic                  op;
    logic [STRENGTH_W-1:0] strength;
    logic [ANGLE_W-1:0]    spoke_angle;
    logic                  last_sample;
    logic [STRENGTH_W-1:0] map_index;
    logic [CLASS_W-1:0]    map_class;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  blob_angle;
    logic [RADIUS_W-1:0] blob_start;
    logic [RADIUS_W-1:0] blob_end;
    logic [CLASS_W-1:0]  blob_class;
    logic                is_final;
  } out_item_t;

  // classified sample handed from the front to the run tracker
  typedef struct packed {
    logic [CLASS_W-1:0]  cls;
    logic [RADIUS_W-1:0] pos;
    logic [ANGLE_W-1:0]  angle;
    logic                last;
  } sample_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
  } queue_status_t;

endpackage

// ===== hw/rtl/radar_spoke_run_length_blobs.sv =====
// top level of the radar spoke run-length blob extractor
// Takes one transaction per clock: a spoke sample or a class map write. A
// sample is classified through the 256-entry class map (one registered read
// per cycle) and then handed through a four-entry queue to the run tracker,
// which closes runs of equal class along the radius. A sample produces no
// blob, one blob, or two blobs when the last sample of a spoke both changes
// the class and flushes the open run; blobs leave through a four-entry output
// queue at one per cycle, so sustained input is one transaction per cycle
// except where two-blob spoke ends arrive faster than the output drains or
// the receiver stalls long enough to fill both queues. The first blob of a
// sample passes the front's staging registers, the sample queue and the output
// queue before it is valid on the output. Map writes produce nothing and may
// sit inside a spoke; a class map entry must be written before any sample
// selects it.
module radar_spoke_run_length_blobs #(
  parameter int unsigned LINES_PER_TURN    = 2048,
  parameter int unsigned RETURNS_PER_SPOKE = 1024,
  parameter int unsigned NUM_CLASSES       = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rslb_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rslb_pkg::out_item_t out_data_o
);
  import rslb_pkg::*;

  queue_status_t q_status;
  logic          push, pop, q_valid;
  sample_t       push_data, q_data;

  rslb_front #(
    .LINES_PER_TURN   (LINES_PER_TURN),
    .RETURNS_PER_SPOKE(RETURNS_PER_SPOKE),
    .NUM_CLASSES      (NUM_CLASSES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_data_o(push_data)
  );

  rslb_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .status_o   (q_status),
    .pop_i      (pop),
    .pop_valid_o(q_valid),
    .pop_data_o (q_data)
  );

  rslb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_data_i  (q_data),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hw/rtl/rslb_front.sv =====
// front end: class map, radius counter, angle reduction and sample classification
module rslb_front #(
  parameter int unsigned LINES_PER_TURN    = 2048,
  parameter int unsigned RETURNS_PER_SPOKE = 1024,
  parameter int unsigned NUM_CLASSES       = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rslb_pkg::in_item_t     in_data_i,
  input  rslb_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output rslb_pkg::sample_t      push_data_o
);
  import rslb_pkg::*;

  localparam int unsigned RC_W = $clog2(RETURNS_PER_SPOKE + 1);
  localparam logic [RC_W-1:0] RC_MAX  = RC_W'(RETURNS_PER_SPOKE);
  localparam logic [RC_W-1:0] POS_MAX = RC_W'(RETURNS_PER_SPOKE - 1);

  logic [CLASS_W-1:0] class_map [MAP_DEPTH];

  logic                s1_valid_q, s1_valid_d;
  logic [CLASS_W-1:0]  rd_class_q;
  logic [ANGLE_W-1:0]  angle_q;
  logic [RADIUS_W-1:0] pos_q;
  logic                last_q;
  logic [RC_W-1:0]     rc_q, rc_d;

  logic                accept, take_sample, take_write;
  logic [RC_W-1:0]     pos;
  logic [16:0]         ang_red;

  assign in_stall_o  = s1_valid_q & q_status_i.full;
  assign accept      = in_valid_i & ~in_stall_o;
  assign take_sample = accept & (in_data_i.op == OP_SAMPLE);
  assign take_write  = accept & (in_data_i.op == OP_MAP_WRITE);

  assign push_o = s1_valid_q & ~q_status_i.full;

  // angle modulo the line count by restoring subtraction of scaled multiples
  always_comb begin
    ang_red = 17'(in_data_i.spoke_angle);
    for (int k = 3; k >= 0; k--) begin
      if (ang_red >= 17'(LINES_PER_TURN << k)) begin
        ang_red = ang_red - 17'(LINES_PER_TURN << k);
      end
    end
  end

  // overlong spokes keep reporting the last radius
  assign pos = (rc_q >= POS_MAX) ? POS_MAX : rc_q;

  always_comb begin
    rc_d = rc_q;
    if (take_sample) begin
      if (in_data_i.last_sample) begin
        rc_d = '0;
      end else if (rc_q < RC_MAX) begin
        rc_d = rc_q + RC_W'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take_sample) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      rc_q       <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      rc_q       <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_write) begin
      class_map[in_data_i.map_index] <= in_data_i.map_class;
    end
    if (take_sample) begin
      rd_class_q <= class_map[in_data_i.strength];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_sample) begin
      angle_q <= ang_red[ANGLE_W-1:0];
      pos_q   <= RADIUS_W'(pos);
      last_q  <= in_data_i.last_sample;
    end
  end

  always_comb begin
    push_data_o.cls   = (int'(rd_class_q) >= NUM_CLASSES) ? CLASS_NONE : rd_class_q;
    push_data_o.pos   = pos_q;
    push_data_o.angle = angle_q;
    push_data_o.last  = last_q;
  end

  a_rc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= RC_MAX)
    else $error("radius counter beyond saturation");

  a_rc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_sample && in_data_i.last_sample |=> rc_q == '0)
    else $error("radius counter not cleared at end of spoke");

  a_sample_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_sample |=> s1_valid_q)
    else $error("accepted sample not staged");

endmodule

// ===== hw/rtl/rslb_fifo.sv =====
// short queue of classified samples between the front and the run tracker
module rslb_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  rslb_pkg::sample_t       push_data_i,
  output rslb_pkg::queue_status_t status_o,
  input  logic                    pop_i,
  output logic                    pop_valid_o,
  output rslb_pkg::sample_t       pop_data_o
);
  import rslb_pkg::*;

  sample_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign status_o.full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o   = (cnt_q != '0);
  assign pop_data_o    = entries[rd_q];

  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & pop_valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries[wr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("sample queue overfilled");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 || cnt_q == QCNT_W'(QUEUE_DEPTH) || wr_q != rd_q)
    else $error("sample queue pointers disagree with count");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
    else $error("sample queue count not advanced on push");

endmodule

// ===== hw/rtl/rslb_back.sv =====
// run tracker: follows class runs along the radius and queues the blobs
module rslb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  rslb_pkg::sample_t   in_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rslb_pkg::out_item_t out_data_o
);
  import rslb_pkg::*;

  out_item_t           oq [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  logic [CLASS_W-1:0]  prev_q, prev_d;
  logic [RADIUS_W-1:0] begin_q, begin_d, end_q, end_d;

  logic                take, out_pop, emit0, emit1;
  logic [CLASS_W-1:0]  nprev;
  logic [RADIUS_W-1:0] nbeg, nend;
  out_item_t           blob0, blob1;

  // room for the two blobs a spoke end can produce
  assign take    = in_valid_i & (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop_o   = take;
  assign out_pop = out_valid_o & ~out_stall_i;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = oq[rd_q];

  always_comb begin
    emit0 = (in_data_i.cls != prev_q) && (prev_q != CLASS_NONE);
    blob0 = '{blob_angle: in_data_i.angle, blob_start: begin_q, blob_end: end_q,
              blob_class: prev_q, is_final: 1'b0};

    nprev = prev_q;
    nbeg  = begin_q;
    nend  = end_q;
    if (in_data_i.cls == prev_q) begin
      if (prev_q != CLASS_NONE) begin
        nend = in_data_i.pos + RADIUS_W'(1);
      end
    end else begin
      nprev = in_data_i.cls;
      if (in_data_i.cls != CLASS_NONE) begin
        nbeg = in_data_i.pos;
        nend = in_data_i.pos + RADIUS_W'(1);
      end
    end

    // flush of the open run at the end of the spoke
    emit1 = in_data_i.last && (nprev != CLASS_NONE);
    blob1 = '{blob_angle: in_data_i.angle, blob_start: nbeg, blob_end: nend,
              blob_class: nprev, is_final: 1'b1};
  end

  always_comb begin
    prev_d  = prev_q;
    begin_d = begin_q;
    end_d   = end_q;
    if (take) begin
      if (in_data_i.last) begin
        prev_d  = CLASS_NONE;
        begin_d = '0;
        end_d   = '0;
      end else begin
        prev_d  = nprev;
        begin_d = nbeg;
        end_d   = nend;
      end
    end
  end

  always_comb begin
    wr_d  = wr_q;
    cnt_d = cnt_q - QCNT_W'(out_pop);
    if (take) begin
      wr_d  = wr_q + QPTR_W'(emit0) + QPTR_W'(emit1);
      cnt_d = cnt_q + QCNT_W'(emit0) + QCNT_W'(emit1) - QCNT_W'(out_pop);
    end
    rd_d = out_pop ? rd_q + QPTR_W'(1) : rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= CLASS_NONE;
      begin_q <= '0;
      end_q   <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      prev_q  <= prev_d;
      begin_q <= begin_d;
      end_q   <= end_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (emit0) begin
        oq[wr_q] <= blob0;
      end
      if (emit1) begin
        oq[emit0 ? wr_q + QPTR_W'(1) : wr_q] <= blob1;
      end
    end
  end

  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("blob queue overfilled");

  a_class_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.blob_class != CLASS_NONE)
    else $error("blob with class none queued");

  a_spoke_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_data_i.last |=> prev_q == CLASS_NONE && begin_q == '0 && end_q == '0)
    else $error("run state not cleared at end of spoke");

endmodule

// ===== tb/radar_spoke_blob_checker.sv =====
// checker that predicts the blobs of the spoke run-length extractor and compares them
`timescale 1ns / 100ps

module radar_spoke_blob_checker #(
  parameter int unsigned LINES_PER_TURN    = 2048,
  parameter int unsigned RETURNS_PER_SPOKE = 1024,
  parameter int unsigned NUM_CLASSES       = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  rslb_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rslb_pkg::out_item_t out_data_i,
  output int                  mismatch_count_o,
  output int                  pending_blobs_o,
  output int                  blobs_checked_o,
  output int                  spokes_closed_o
);
  import rslb_pkg::*;

  logic [CLASS_W-1:0]  class_lut [MAP_DEPTH];
  logic [CLASS_W-1:0]  open_class = CLASS_NONE;
  logic [RADIUS_W-1:0] samples_in_spoke = '0;
  logic [RADIUS_W-1:0] run_first = '0;
  logic [RADIUS_W-1:0] run_past = '0;
  out_item_t           expected_blobs [$];
  int                  mismatches = 0;
  int                  blobs_checked = 0;
  int                  spokes_closed = 0;

  function automatic out_item_t close_run(input logic [ANGLE_W-1:0] angle, input logic fin);
    out_item_t blob;
    blob.blob_angle = angle;
    blob.blob_start = run_first;
    blob.blob_end   = run_past;
    blob.blob_class = open_class;
    blob.is_final   = fin;
    return blob;
  endfunction

  task automatic track_item(input in_item_t item);
    logic [RADIUS_W-1:0] pos;
    logic [CLASS_W-1:0]  cls;
    logic [ANGLE_W-1:0]  angle;
    if (item.op == OP_MAP_WRITE) begin
      class_lut[item.map_index] = item.map_class;
      return;
    end
    angle = ANGLE_W'(item.spoke_angle % LINES_PER_TURN);
    // radius clamps at the last return, the counter saturates one above
    if (samples_in_spoke > RETURNS_PER_SPOKE - 1) begin
      pos = RADIUS_W'(RETURNS_PER_SPOKE - 1);
    end else begin
      pos = samples_in_spoke;
    end
    if (samples_in_spoke < RETURNS_PER_SPOKE) samples_in_spoke++;
    cls = class_lut[item.strength];
    if (int'(cls) >= NUM_CLASSES) cls = CLASS_NONE;
    if (cls == open_class) begin
      if (open_class != CLASS_NONE) run_past = pos + 1'b1;
    end else if (open_class == CLASS_NONE) begin
      run_first  = pos;
      run_past   = pos + 1'b1;
      open_class = cls;
    end else begin
      expected_blobs.push_back(close_run(angle, 1'b0));
      open_class = cls;
      if (cls != CLASS_NONE) begin
        run_first = pos;
        run_past  = pos + 1'b1;
      end
    end
    if (item.last_sample) begin
      if (open_class != CLASS_NONE) expected_blobs.push_back(close_run(angle, 1'b1));
      open_class       = CLASS_NONE;
      samples_in_spoke = '0;
      run_first        = '0;
      run_past         = '0;
      spokes_closed++;
    end
  endtask

  task automatic compare_blob(input out_item_t got);
    out_item_t want;
    blobs_checked++;
    if (expected_blobs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: blob with none pending: angle %0d start %0d end %0d class %0d final %0d",
                 $time, got.blob_angle, got.blob_start, got.blob_end, got.blob_class,
                 got.is_final);
      end
      return;
    end
    want = expected_blobs.pop_front();
    if (got.blob_angle !== want.blob_angle || got.blob_start !== want.blob_start ||
        got.blob_end !== want.blob_end || got.blob_class !== want.blob_class ||
        got.is_final !== want.is_final) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: blob differs: expected angle %0d start %0d end %0d class %0d final %0d",
                 $time, want.blob_angle, want.blob_start, want.blob_end, want.blob_class,
                 want.is_final);
        $display("%0t:                   got angle %0d start %0d end %0d class %0d final %0d",
                 $time, got.blob_angle, got.blob_start, got.blob_end, got.blob_class,
                 got.is_final);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_class       = CLASS_NONE;
      samples_in_spoke = '0;
      run_first        = '0;
      run_past         = '0;
      expected_blobs.delete();
    end else begin
      // a blob leaving at this edge never comes from a transaction taken at the same edge
      if (out_valid_i && !out_stall_i) compare_blob(out_data_i);
      if (in_valid_i && !in_stall_i) track_item(in_data_i);
    end
    mismatch_count_o <= mismatches;
    pending_blobs_o  <= expected_blobs.size();
    blobs_checked_o  <= blobs_checked;
    spokes_closed_o  <= spokes_closed;
  end

endmodule

// ===== tb/radar_spoke_run_length_blobs_test.sv =====
// stimulus and verdict for the radar spoke run-length blob extractor
`timescale 1ns / 100ps

module radar_spoke_run_length_blobs_test;
  import rslb_pkg::*;

  localparam int unsigned LINES_PER_TURN    = 2048;
  localparam int unsigned RETURNS_PER_SPOKE = 1024;
  localparam int unsigned NUM_CLASSES       = 8;
  localparam int          PHASE_ITEMS       = 180;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      spoke_valid = 1'b0;
  logic      spoke_stall;
  in_item_t  spoke_item = '0;
  logic      blob_valid;
  logic      blob_stall = 1'b0;
  out_item_t blob_item;

  int mismatch_count;
  int pending_blobs;
  int blobs_checked;
  int spokes_closed;

  int   idle_pct = 0;
  int   stall_pct = 0;
  int   items_sent = 0;
  int   phase_end;
  logic written [MAP_DEPTH];
  logic [STRENGTH_W-1:0] written_idx [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) blob_stall <= ($urandom_range(99) < stall_pct);

  radar_spoke_run_length_blobs #(
    .LINES_PER_TURN    (LINES_PER_TURN),
    .RETURNS_PER_SPOKE (RETURNS_PER_SPOKE),
    .NUM_CLASSES       (NUM_CLASSES)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (spoke_valid),
    .in_stall_o  (spoke_stall),
    .in_data_i   (spoke_item),
    .out_valid_o (blob_valid),
    .out_stall_i (blob_stall),
    .out_data_o  (blob_item)
  );

  radar_spoke_blob_checker #(
    .LINES_PER_TURN    (LINES_PER_TURN),
    .RETURNS_PER_SPOKE (RETURNS_PER_SPOKE),
    .NUM_CLASSES       (NUM_CLASSES)
  ) blob_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (spoke_valid),
    .in_stall_i       (spoke_stall),
    .in_data_i        (spoke_item),
    .out_valid_i      (blob_valid),
    .out_stall_i      (blob_stall),
    .out_data_i       (blob_item),
    .mismatch_count_o (mismatch_count),
    .pending_blobs_o  (pending_blobs),
    .blobs_checked_o  (blobs_checked),
    .spokes_closed_o  (spokes_closed)
  );

  // valid stays high from one transaction to the next unless a gap is drawn
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      spoke_valid <= 1'b0;
      @(posedge clk);
    end
    spoke_valid <= 1'b1;
    spoke_item  <= item;
    @(posedge clk);
    while (spoke_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_map_write(input logic [STRENGTH_W-1:0] idx,
                                input logic [CLASS_W-1:0] cls);
    in_item_t item;
    item           = in_item_t'($urandom);
    item.op        = OP_MAP_WRITE;
    item.map_index = idx;
    item.map_class = cls;
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
    send_item(item);
  endtask

  task automatic send_sample(input logic [STRENGTH_W-1:0] strength,
                             input logic [ANGLE_W-1:0] angle, input logic last);
    in_item_t item;
    item             = in_item_t'($urandom);
    item.op          = OP_SAMPLE;
    item.strength    = strength;
    item.spoke_angle = angle;
    item.last_sample = last;
    send_item(item);
  endtask

  // only strengths whose map entry has been written may be sampled
  function automatic logic [STRENGTH_W-1:0] pick_strength();
    return written_idx[$urandom_range(written_idx.size() - 1)];
  endfunction

  // strength is held for long runs up to calm_until, then changes often
  task automatic send_spoke(input int length, input int calm_until);
    logic [ANGLE_W-1:0]    angle;
    logic [STRENGTH_W-1:0] strength;
    angle    = ANGLE_W'($urandom);
    strength = pick_strength();
    for (int k = 0; k < length; k++) begin
      if ($urandom_range(99) < 8) send_map_write(STRENGTH_W'($urandom), CLASS_W'($urandom));
      if ($urandom_range(99) < 10) angle = ANGLE_W'($urandom);
      if ($urandom_range(99) < (k < calm_until ? 2 : 45)) strength = pick_strength();
      send_sample(strength, angle, k == length - 1);
    end
  endtask

  initial begin
    for (int i = 0; i < MAP_DEPTH; i++) written[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_map_write(8'h00, 3'd0);
    send_map_write(8'hFF, 3'd7);
    send_map_write(8'h01, 3'd1);
    send_map_write(8'h80, 3'd6);
    // class changes along the radius, open run flushed at the end
    send_sample(8'hFF, 11'd0, 1'b0);
    send_sample(8'hFF, 11'd0, 1'b0);
    send_sample(8'h01, 11'd0, 1'b0);
    send_sample(8'h00, 11'd0, 1'b0);
    send_sample(8'h80, 11'd0, 1'b1);
    // single-sample spokes, none and classed
    send_sample(8'h00, 11'd2047, 1'b1);
    send_sample(8'hFF, 11'd2047, 1'b1);
    // change and flush on the same last sample, angle moving within the spoke
    send_sample(8'h01, 11'd5, 1'b0);
    send_sample(8'hFF, 11'd6, 1'b1);
    // map entry rewritten while its strength is inside an open run
    send_sample(8'h80, 11'd9, 1'b0);
    send_map_write(8'h80, 3'd5);
    send_sample(8'h80, 11'd9, 1'b0);
    send_sample(8'h80, 11'd9, 1'b1);
    // run closed by none, spoke ends with nothing open
    send_map_write(8'hAA, 3'd2);
    send_sample(8'hAA, 11'h555, 1'b0);
    send_sample(8'h00, 11'h2AA, 1'b0);
    send_sample(8'h00, 11'h2AA, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 54;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 54;
        end
        default: begin
          idle_pct = 20;
          stall_pct <= 20;
        end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        send_spoke($urandom_range(99) < 85 ? $urandom_range(12, 1) : $urandom_range(80, 13), 0);
      end
    end
    // overlong spoke: radius saturates, class changes past the last return
    send_spoke(RETURNS_PER_SPOKE + 6, RETURNS_PER_SPOKE - 4);
    spoke_valid <= 1'b0;

    for (int w = 0; w < 20000 && pending_blobs != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d transactions over %0d spokes, checked %0d blobs",
             items_sent, spokes_closed, blobs_checked);
    $display("idle phases: none, sender gaps, receiver stalls, both; one overlong spoke");
    if (pending_blobs != 0) $display("%0d predicted blobs never arrived", pending_blobs);
    if (mismatch_count == 0 && pending_blobs == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for transactions");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rslb_pkg.sv
hw/rtl/rslb_front.sv
hw/rtl/rslb_fifo.sv
hw/rtl/rslb_back.sv
hw/rtl/radar_spoke_run_length_blobs.sv
tb/radar_spoke_blob_checker.sv
tb/radar_spoke_run_length_blobs_test.sv
